// ===== sv/wvnn_pkg.sv =====
package wvnn_pkg;

  localparam int unsigned MaxWeightsDef    = 256;
  localparam int unsigned MaxObjectivesDef = 8;
  localparam int unsigned MaxNeighborsDef  = 32;
  localparam int unsigned ScratchDepth     = 256;

  localparam int unsigned CompW  = 17;
  localparam int unsigned DistW  = 36;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned RankW  = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CompW-1:0] OneQ16 = 17'h10000;
  localparam logic [DistW-1:0] DistMax = '1;

  localparam logic [CfgIdxW-1:0] RegNumWeights    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegNumObjectives = 2'd1;
  localparam logic [CfgIdxW-1:0] RegNeighborCount = 2'd2;
  localparam logic [CfgIdxW-1:0] RegDistMargin    = 2'd3;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic [CompW-1:0] component_value;
    logic [2:0]       objective_index;
    logic [IdxW-1:0]  entry_index;
    logic             opcode;
  } in_item_t;

  typedef struct packed {
    logic [DistW-1:0] squared_distance;
    logic [RankW-1:0] neighbor_rank;
    logic [IdxW-1:0]  neighbor_index;
  } out_item_t;

endpackage

// ===== sv/weight_vector_nearest_neighbors.sv =====
// Channel  | Direction | Payload
// s_axis   | in        | tdata: opcode, entry_index[8], objective_index[3], component_value[17]
// m_axis   | out       | tdata: neighbor_index[8], neighbor_rank[5], squared_distance[36]; tlast
// cfg      | in        | cfg_addr_i register index, cfg_data_i value
// A write request is accepted and the next request can follow at once.
// A query first reduces entry modulo nw by repeated subtraction, then computes the
// distances (two weight reads, a square and an accumulate per component), then runs
// one selection-sort pass per rank k, then sends each result, waiting out any stall.
// Reset clears control state only; memories are undefined until written.
// m_axis stalls hold the sequencer; s_axis waits while busy.
module weight_vector_nearest_neighbors #(
  parameter int unsigned MAX_WEIGHTS    = wvnn_pkg::MaxWeightsDef,
  parameter int unsigned MAX_OBJECTIVES = wvnn_pkg::MaxObjectivesDef,
  parameter int unsigned MAX_NEIGHBORS  = wvnn_pkg::MaxNeighborsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // opcode, entry_index, objective_index, component_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // neighbor_index, neighbor_rank, squared_distance
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [wvnn_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  logic [wvnn_pkg::CfgDataW-1:0] cfg_data_i
);
  import wvnn_pkg::*;

  localparam int unsigned WCap  = (MAX_WEIGHTS < ScratchDepth) ? MAX_WEIGHTS : ScratchDepth;
  localparam int unsigned NCap  = (MAX_NEIGHBORS < 32) ? MAX_NEIGHBORS : 32;
  localparam int unsigned WAW   = $clog2(MAX_WEIGHTS);
  localparam int unsigned OAW   = (MAX_OBJECTIVES > 1) ? $clog2(MAX_OBJECTIVES) : 1;
  localparam int unsigned MemD  = MAX_WEIGHTS * (1 << OAW);
  localparam int unsigned MemAW = WAW + OAW;
  localparam int unsigned CntW  = 9;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MOD   = 4'd1;
  localparam logic [3:0] S_DRD   = 4'd2;
  localparam logic [3:0] S_DACC  = 4'd3;
  localparam logic [3:0] S_DWR   = 4'd4;
  localparam logic [3:0] S_KRD   = 4'd5;
  localparam logic [3:0] S_KLAT  = 4'd6;
  localparam logic [3:0] S_JRD   = 4'd7;
  localparam logic [3:0] S_JCMP  = 4'd8;
  localparam logic [3:0] S_KWB   = 4'd9;
  localparam logic [3:0] S_ORD   = 4'd10;
  localparam logic [3:0] S_OLAT  = 4'd11;
  localparam logic [3:0] S_OOUT  = 4'd12;
  localparam logic [3:0] S_DMUL  = 4'd13;

  logic [CompW-1:0] wmem [MemD];
  logic [DistW-1:0] dmem [ScratchDepth];
  logic [IdxW-1:0]  imem [ScratchDepth];

  logic [3:0]  st_q, st_d;
  logic [8:0]  nw_cfg_q;
  logic [3:0]  nobj_cfg_q;
  logic [5:0]  nc_cfg_q;
  logic [15:0] margin_q;

  logic [CntW-1:0] nw_q, nc_q, id_q, j_q, k_q, jr_q;
  logic [4:0]      c_q;
  logic [3:0]      nobj_q;
  logic [DistW-1:0] acc_q, kd_q, diff2_q;
  logic [IdxW-1:0]  ki_q;
  logic [CompW-1:0] a_q;
  logic             phase_q;
  logic [CompW-1:0] wrd_q;
  logic [DistW-1:0] drd_q;
  logic [IdxW-1:0]  ird_q;
  out_item_t        out_q;
  logic             ovalid_q, olast_q;

  in_item_t in;
  assign in = in_item_t'(s_axis_tdata[28:0]);

  assign s_axis_tready = (st_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {7'd0, out_q};
  assign m_axis_tlast  = olast_q;

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // weight memory port
  logic             w_we;
  logic [MemAW-1:0] w_wa, w_ra;
  logic [CompW-1:0] w_wd, wclip;
  assign wclip = (in.component_value > OneQ16) ? OneQ16 : in.component_value;
  assign w_we = in_fire && (in.opcode == OpWrite) &&
                (32'(in.entry_index) < MAX_WEIGHTS) &&
                (32'(in.objective_index) < MAX_OBJECTIVES);
  assign w_wa = {WAW'(in.entry_index), OAW'(in.objective_index)};
  assign w_wd = wclip;
  // read alternates id-row and j-row component c
  assign w_ra = {WAW'(phase_q ? j_q : id_q), OAW'(c_q)};

  always_ff @(posedge clk_i) begin
    if (w_we) wmem[w_wa] <= w_wd;
    wrd_q <= wmem[w_ra];
  end

  // scratch memories
  logic             s_we;
  logic [7:0]       s_wa, s_ra;
  logic [DistW-1:0] s_wd;
  logic [IdxW-1:0]  s_wi;

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      dmem[s_wa] <= s_wd;
      imem[s_wa] <= s_wi;
    end
    drd_q <= dmem[s_ra];
    ird_q <= imem[s_ra];
  end

  // distance step
  logic [CompW-1:0]   diff;
  logic [2*CompW-1:0] sq;
  logic [DistW:0]     accsum;
  assign diff   = (a_q > wrd_q) ? a_q - wrd_q : wrd_q - a_q;
  assign sq     = diff * diff;
  assign accsum = {1'b0, acc_q} + {1'b0, diff2_q};

  logic swap;
  assign swap = kd_q > ({1'b0, drd_q} + {21'd0, margin_q});

  logic [CntW-1:0] nw_clamp, nc_clamp0;
  logic [3:0]      nobj_clamp;
  assign nw_clamp  = (nw_cfg_q == 0) ? 9'd1 : (nw_cfg_q > 9'(WCap)) ? 9'(WCap) : nw_cfg_q;
  assign nobj_clamp = (nobj_cfg_q == 0) ? 4'd1 :
                      ({1'b0, nobj_cfg_q} > 5'(MAX_OBJECTIVES)) ? 4'(MAX_OBJECTIVES) : nobj_cfg_q;
  assign nc_clamp0 = (nc_cfg_q == 0) ? 9'd1 :
                     ({1'b0, nc_cfg_q} > 7'(NCap)) ? 9'(NCap) : {3'd0, nc_cfg_q};

  always_comb begin
    st_d = st_q;
    s_we = 1'b0;
    s_wa = j_q[7:0];
    s_wd = acc_q;
    s_wi = j_q[7:0];
    s_ra = jr_q[7:0];
    case (st_q)
      S_IDLE:  if (in_fire && in.opcode == OpQuery) st_d = S_MOD;
      S_MOD:   if (id_q < nw_q) st_d = S_DRD;
      S_DRD:   st_d = S_DACC;
      S_DACC:  st_d = S_DMUL;
      S_DMUL:  if (phase_q) st_d = (c_q + 5'd1 == {1'b0, nobj_q}) ? S_DWR : S_DRD;
      S_DWR: begin
        s_we = 1'b1;
        st_d = (j_q + 9'd1 == nw_q) ? S_KRD : S_DRD;
      end
      S_KRD:   st_d = S_KLAT;
      S_KLAT:  st_d = (k_q + 9'd1 >= nw_q) ? S_KWB : S_JRD;
      S_JRD:   st_d = S_JCMP;
      S_JCMP: begin
        if (swap) begin
          s_we = 1'b1;
          s_wa = j_q[7:0];
          s_wd = kd_q;
          s_wi = ki_q;
        end
        st_d = (j_q + 9'd1 >= nw_q) ? S_KWB : S_JRD;
      end
      S_KWB: begin
        s_we = 1'b1;
        s_wa = k_q[7:0];
        s_wd = kd_q;
        s_wi = ki_q;
        st_d = (k_q + 9'd1 == nc_q) ? S_ORD : S_KRD;
      end
      S_ORD:   st_d = S_OLAT;
      S_OLAT:  st_d = S_OOUT;
      S_OOUT:  if (!ovalid_q || m_axis_tready)
                 st_d = (k_q + 9'd1 == nc_q) ? S_IDLE : S_ORD;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      nw_cfg_q   <= 9'd256;
      nobj_cfg_q <= 4'd3;
      nc_cfg_q   <= 6'd20;
      margin_q   <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          RegNumWeights:    nw_cfg_q   <= {1'b0, cfg_data_i[7:0]} | {cfg_data_i[8], 8'd0};
          RegNumObjectives: nobj_cfg_q <= cfg_data_i[3:0];
          RegNeighborCount: nc_cfg_q   <= cfg_data_i[5:0];
          RegDistMargin:    margin_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (st_q == S_OOUT && (!ovalid_q || m_axis_tready)) begin
        ovalid_q <= 1'b1;
      end else if (ovalid_q && m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        nw_q   <= nw_clamp;
        nobj_q <= nobj_clamp;
        nc_q   <= (nc_clamp0 > nw_clamp) ? nw_clamp : nc_clamp0;
        id_q   <= {1'b0, in.entry_index};
        j_q    <= '0;
        c_q    <= '0;
        acc_q  <= '0;
        phase_q <= 1'b0;
      end
      S_MOD: if (id_q >= nw_q) id_q <= id_q - nw_q;
      S_DRD: phase_q <= 1'b1;
      S_DACC: begin
        a_q     <= wrd_q;
        phase_q <= 1'b0;
      end
      S_DMUL: begin
        if (phase_q) begin
          acc_q <= accsum[DistW] ? DistMax : accsum[DistW-1:0];
          c_q   <= c_q + 5'd1;
        end
        phase_q <= ~phase_q;
      end
      S_DWR: begin
        j_q   <= j_q + 9'd1;
        jr_q  <= '0;
        k_q   <= '0;
        c_q   <= '0;
        acc_q <= '0;
      end
      S_KRD: ;
      S_KLAT: begin
        kd_q <= drd_q;
        ki_q <= ird_q;
        j_q  <= k_q + 9'd1;
        jr_q <= k_q + 9'd1;
      end
      S_JRD: jr_q <= j_q + 9'd1;
      S_JCMP: begin
        if (swap) begin
          kd_q <= drd_q;
          ki_q <= ird_q;
        end
        j_q <= j_q + 9'd1;
      end
      S_KWB: begin
        if (k_q + 9'd1 == nc_q) begin
          k_q  <= '0;
          jr_q <= '0;
        end else begin
          k_q  <= k_q + 9'd1;
          jr_q <= k_q + 9'd1;
        end
      end
      S_OOUT: if (!ovalid_q || m_axis_tready) begin
        out_q.neighbor_index   <= ird_q;
        out_q.neighbor_rank    <= k_q[4:0];
        out_q.squared_distance <= drd_q;
        olast_q <= (k_q + 9'd1 == nc_q);
        k_q  <= k_q + 9'd1;
        jr_q <= k_q + 9'd1;
      end
      default: ;
    endcase
    diff2_q <= DistW'(sq);
  end

endmodule

// ===== dv/weight_vector_nearest_neighbors_checker.sv =====
module weight_vector_nearest_neighbors_checker
  import wvnn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [55:0]         m_axis_tdata,
  input  logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IdxW-1:0]  index;
    logic [RankW-1:0] rank;
    logic [DistW-1:0] sq_dist;
    logic             last;
  } neighbor_t;

  neighbor_t        neighbor_q[$];
  logic [CompW-1:0] weights [256][8];
  logic [8:0]       weight_count;
  logic [3:0]       num_objectives;
  logic [5:0]       neighbor_count;
  logic [15:0]      distance_margin;
  int               fails;

  function automatic logic [63:0] squared_dist(int a, int b, int nobj);
    logic [63:0] sum;
    logic [63:0] diff;
    sum = 0;
    for (int c = 0; c < nobj; c++) begin
      diff = (weights[a][c] > weights[b][c]) ? 64'(weights[a][c] - weights[b][c])
                                             : 64'(weights[b][c] - weights[a][c]);
      sum += diff * diff;
      if (sum > 64'(DistMax)) sum = 64'(DistMax);
    end
    return sum;
  endfunction

  function automatic void predict_neighbors(int entry);
    logic [63:0] dist_v [256];
    int          idx [256];
    logic [63:0] td;
    int          ti, nw, nobj, nc, id;
    neighbor_t   n;
    nw   = (weight_count == 0) ? 1 : (weight_count > 256) ? 256 : int'(weight_count);
    nobj = (num_objectives == 0) ? 1 : (num_objectives > 8) ? 8 : int'(num_objectives);
    nc   = (neighbor_count == 0) ? 1 : (neighbor_count > 32) ? 32 : int'(neighbor_count);
    if (nc > nw) nc = nw;
    id = entry % nw;
    for (int j = 0; j < nw; j++) begin
      dist_v[j] = squared_dist(id, j, nobj);
      idx[j]    = j;
    end
    for (int k = 0; k < nc; k++) begin
      for (int j = k + 1; j < nw; j++) begin
        if (dist_v[k] > dist_v[j] + 64'(distance_margin)) begin
          td = dist_v[k]; dist_v[k] = dist_v[j]; dist_v[j] = td;
          ti = idx[k];    idx[k]    = idx[j];    idx[j]    = ti;
        end
      end
    end
    for (int k = 0; k < nc; k++) begin
      n.index   = idx[k][IdxW-1:0];
      n.rank    = k[RankW-1:0];
      n.sq_dist = dist_v[k][DistW-1:0];
      n.last    = (k + 1 == nc);
      neighbor_q.push_back(n);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    in_item_t  req;
    neighbor_t got, want;
    if (!rst_ni) begin
      weight_count    <= 9'd256;
      num_objectives  <= 4'd3;
      neighbor_count  <= 6'd20;
      distance_margin <= 16'd0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.index   = m_axis_tdata[7:0];
        got.rank    = m_axis_tdata[12:8];
        got.sq_dist = m_axis_tdata[48:13];
        got.last    = m_axis_tlast;
        if (neighbor_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected neighbor, actual %p", $time, got);
        end else begin
          want = neighbor_q.pop_front();
          if (got !== want) begin
            fails++;
            $display("%0t: neighbor mismatch, expected %p actual %p", $time, want, got);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req = in_item_t'(s_axis_tdata[28:0]);
        if (req.opcode == OpWrite)
          weights[req.entry_index][req.objective_index] <=
            (req.component_value > OneQ16) ? OneQ16 : req.component_value;
        else
          predict_neighbors(int'(req.entry_index));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr_i)
          RegNumWeights:    weight_count    <= cfg_data_i[8:0];
          RegNumObjectives: num_objectives  <= cfg_data_i[3:0];
          RegNeighborCount: neighbor_count  <= cfg_data_i[5:0];
          RegDistMargin:    distance_margin <= cfg_data_i;
          default: ;
        endcase
      end
      fail_count_o = fails;
      pending_o    = neighbor_q.size();
    end
  end

endmodule

// ===== dv/weight_vector_nearest_neighbors_tb.sv =====
module weight_vector_nearest_neighbors_tb;
  import wvnn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3000000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid, s_axis_tready;
  logic [31:0]         s_axis_tdata;
  logic                m_axis_tvalid, m_axis_tready;
  logic [55:0]         m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_valid_i, cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_addr_i;
  logic [CfgDataW-1:0] cfg_data_i;
  int                  fail_count, pending;
  int                  cycles = 0;
  int                  send_idle_pct, recv_idle_pct;
  logic                hold_start, rx_hold;

  always #5 clk_i = ~clk_i;

  weight_vector_nearest_neighbors DUT (.*);

  weight_vector_nearest_neighbors_checker u_checker (
    .fail_count_o(fail_count), .pending_o(pending), .*
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i)
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);

  initial begin
    rx_hold = 1'b0;
    wait (hold_start);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (3000) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  task automatic send_request(logic op, logic [7:0] entry, logic [2:0] obj,
                              logic [16:0] value);
    in_item_t req;
    req = '{component_value: value, objective_index: obj, entry_index: entry, opcode: op};
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b0, req};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic query(logic [7:0] entry);
    send_request(OpQuery, entry, 3'($urandom), 17'($urandom));
  endtask

  function automatic logic [16:0] rand_component();
    int r;
    r = $urandom_range(99);
    if (r < 10) return OneQ16;
    if (r < 20) return 17'($urandom_range(131071, 65537));
    if (r < 25) return '0;
    return 17'($urandom_range(65536));
  endfunction

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [CfgIdxW-1:0] addr, int value);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= CfgDataW'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_all(int nw, int nobj, int nc, int margin);
    set_reg(RegNumWeights, nw);
    set_reg(RegNumObjectives, nobj);
    set_reg(RegNeighborCount, nc);
    set_reg(RegDistMargin, margin);
  endtask

  initial begin
    int margin;
    hold_start    = 1'b0;
    send_idle_pct = 22;
    recv_idle_pct = 86;
    rst_ni        = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_addr_i    <= '0;
    cfg_data_i    <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int e = 0; e < 8; e++)
      for (int c = 0; c < 8; c++)
        send_request(OpWrite, 8'(e), 3'(c), rand_component());
    send_request(OpWrite, 8'd7, 3'd7, 17'h1ffff);
    send_request(OpWrite, 8'd0, 3'd0, 17'h0);
    drain();

    set_all(8, 8, 32, 0);
    query(8'd0);
    query(8'd255);
    drain();
    set_all(1, 1, 1, 65535);
    query(8'd0);
    query(8'd200);
    drain();
    set_all(5, 8, 32, 0);
    query(8'd4);
    query(8'd255);
    drain();
    set_all(0, 0, 0, 1);
    query(8'd3);
    drain();
    set_all(3, 15, 63, 4096);
    query(8'd170);
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 22 : (mode == 1) ? 86 : 0;
      recv_idle_pct = (mode == 0) ? 86 : (mode == 1) ? 22 : 0;
      for (int blk = 0; blk < 3; blk++) begin
        margin = $urandom_range(2);
        margin = (margin == 0) ? 0 : (margin == 1) ? $urandom_range(255) : $urandom_range(65535);
        set_all($urandom_range(8, 2), $urandom_range(8, 1), $urandom_range(32, 1), margin);
        if (mode == 2 && blk == 0) begin
          hold_start = 1'b1;
          repeat (4) query(8'($urandom));
        end
        for (int n = 0; n < 7; n++) begin
          if ($urandom_range(99) < 55)
            query(8'($urandom));
          else
            send_request(OpWrite, 8'($urandom_range(9)), 3'($urandom), rand_component());
        end
        drain();
      end
    end

    repeat (50) @(posedge clk_i);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
